// File: sv/assert_macros.svh
// assertion macros used by raster_op_pixel_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// plain property checked every clock outside reset
`define ROPU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: label");

// same-cycle implication
`define ROPU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// next-cycle implication
`define ROPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`else

`define ROPU_ASSERT(label, clk, rst_n, prop)
`define ROPU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ROPU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/ropu_pkg.sv
// types, codes and helper functions of the raster-op pixel unit
`timescale 1ns / 1ps

package ropu_pkg;

    localparam int OPCODE_W  = 6;
    localparam int PIXEL_W   = 32;
    localparam int GLYPH_W   = 8;
    localparam int COLOR_W   = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 32;

    localparam logic [7:0]  ALPHA_FF    = 8'hFF;
    localparam logic [31:0] ALPHA_BYTE  = 32'hFF00_0000;
    localparam logic [31:0] COLOR_MASK  = 32'h00FF_FFFF;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRUSH_COLOR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRUSH_SOLID  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SWAP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PEN_VALUE    = 3'd5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_BLACKNESS    = 6'd0,
        OP_WHITENESS    = 6'd1,
        OP_SRCCOPY      = 6'd2,
        OP_SPNA         = 6'd3,
        OP_DSNA         = 6'd4,
        OP_DSPDXAX      = 6'd5,
        OP_NOTSRCCOPY   = 6'd6,
        OP_DSTINVERT    = 6'd7,
        OP_SRCERASE     = 6'd8,
        OP_NOTSRCERASE  = 6'd9,
        OP_SRCINVERT    = 6'd10,
        OP_SRCAND       = 6'd11,
        OP_SRCPAINT     = 6'd12,
        OP_MERGECOPY    = 6'd13,
        OP_MERGEPAINT   = 6'd14,
        OP_PATCOPY      = 6'd15,
        OP_PATINVERT    = 6'd16,
        OP_PATPAINT     = 6'd17,
        OP_R2_BLACK     = 6'd18,
        OP_R2_NOTMERGE  = 6'd19,
        OP_R2_MASKNOT   = 6'd20,
        OP_R2_NOTCOPY   = 6'd21,
        OP_R2_MASKPNOT  = 6'd22,
        OP_R2_NOT       = 6'd23,
        OP_R2_XOR       = 6'd24,
        OP_R2_NOTMASK   = 6'd25,
        OP_R2_MASK      = 6'd26,
        OP_R2_NOTXOR    = 6'd27,
        OP_R2_NOP       = 6'd28,
        OP_R2_MERGENOT  = 6'd29,
        OP_R2_COPY      = 6'd30,
        OP_R2_MERGEPNOT = 6'd31,
        OP_R2_MERGE     = 6'd32,
        OP_R2_WHITE     = 6'd33
    } ropu_op_t;

    typedef struct packed {
        logic [COLOR_W-1:0] text_color;
        logic [COLOR_W-1:0] brush_color;
        logic               brush_solid;
        logic               channel_swap;
        logic               alpha_mode;
        logic [PIXEL_W-1:0] pen_value;
    } ropu_cfg_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_out;
        logic               error;
    } ropu_res_t;

    // 0x00BBGGRR -> 0xFFRRGGBB, or 0xFFBBGGRR when swapped
    function automatic logic [PIXEL_W-1:0] pack_color(input logic [COLOR_W-1:0] c,
                                                      input logic swap);
        logic [PIXEL_W-1:0] packed_c;
        if (swap)
        begin
            packed_c = {ALPHA_FF, c[23:16], c[15:8], c[7:0]};
        end
        else
        begin
            packed_c = {ALPHA_FF, c[7:0], c[15:8], c[23:16]};
        end
        return packed_c;
    endfunction

    // colour bytes from v, byte 3 from d
    function automatic logic [PIXEL_W-1:0] keep_alpha(input logic [PIXEL_W-1:0] v,
                                                      input logic [PIXEL_W-1:0] d);
        return (v & COLOR_MASK) | (d & ~COLOR_MASK);
    endfunction

endpackage

// File: sv/ropu_cfg_regs.sv
// configuration register file of the raster-op pixel unit
`timescale 1ns / 1ps

module ropu_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ropu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ropu_pkg::CFG_DAT_W-1:0] cfg_data,
    output ropu_pkg::ropu_cfg_t           cfg
);
    import ropu_pkg::*;

    ropu_cfg_t cfg_reg;
    ropu_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEXT_COLOR:   cfg_next.text_color   = cfg_data[COLOR_W-1:0];
                REG_BRUSH_COLOR:  cfg_next.brush_color  = cfg_data[COLOR_W-1:0];
                REG_BRUSH_SOLID:  cfg_next.brush_solid  = cfg_data[0];
                REG_CHANNEL_SWAP: cfg_next.channel_swap = cfg_data[0];
                REG_ALPHA_MODE:   cfg_next.alpha_mode   = cfg_data[0];
                REG_PEN_VALUE:    cfg_next.pen_value    = cfg_data[PIXEL_W-1:0];
                default:          cfg_next = cfg_reg; // index beyond the list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.text_color   <= '0;
            cfg_reg.brush_color  <= '0;
            cfg_reg.brush_solid  <= 1'b1;
            cfg_reg.channel_swap <= 1'b0;
            cfg_reg.alpha_mode   <= 1'b0;
            cfg_reg.pen_value    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/ropu_alu.sv
// per-pixel raster operation logic
`timescale 1ns / 1ps

module ropu_alu (
    input  ropu_pkg::ropu_cfg_t            cfg,
    input  logic [ropu_pkg::OPCODE_W-1:0]  opcode,
    input  logic [ropu_pkg::PIXEL_W-1:0]   src_pixel,
    input  logic [ropu_pkg::PIXEL_W-1:0]   dst_pixel,
    input  logic [ropu_pkg::PIXEL_W-1:0]   pattern_pixel,
    input  logic [ropu_pkg::GLYPH_W-1:0]   glyph_mask,
    output ropu_pkg::ropu_res_t            res
);
    import ropu_pkg::*;

    logic [PIXEL_W-1:0] s;
    logic [PIXEL_W-1:0] d;
    logic [PIXEL_W-1:0] p;
    logic [PIXEL_W-1:0] pen;
    logic [PIXEL_W-1:0] text_argb;
    logic [PIXEL_W-1:0] brush_argb;
    logic [PIXEL_W-1:0] mm;
    ropu_op_t           op;

    assign s   = src_pixel;
    assign d   = dst_pixel;
    assign p   = pattern_pixel;
    assign pen = cfg.pen_value;
    assign op  = ropu_op_t'(opcode);

    assign text_argb  = pack_color(cfg.text_color, cfg.channel_swap);
    assign brush_argb = pack_color(cfg.brush_color, cfg.channel_swap);
    // glyph mask replicated over the three colour bytes
    assign mm = {8'h00, glyph_mask, glyph_mask, glyph_mask};

    always_comb
    begin
        res.pixel_out = d;
        res.error     = 1'b0;
        case (op)
            OP_BLACKNESS:   res.pixel_out = cfg.alpha_mode ? ALPHA_BYTE : '0;
            OP_WHITENESS:   res.pixel_out = '1;
            OP_SRCCOPY:     res.pixel_out = s;
            OP_SPNA:        res.pixel_out = keep_alpha(s & ~p, d);
            OP_DSNA:        res.pixel_out = keep_alpha(~s & d, d);
            OP_DSPDXAX:     res.pixel_out = keep_alpha((mm & text_argb) | (~mm & d), d);
            OP_NOTSRCCOPY:  res.pixel_out = keep_alpha(~s, d);
            OP_DSTINVERT:   res.pixel_out = keep_alpha(~d, d);
            OP_SRCERASE:    res.pixel_out = keep_alpha(s & ~d, d);
            OP_NOTSRCERASE: res.pixel_out = keep_alpha(~s & ~d, d);
            OP_SRCINVERT:   res.pixel_out = keep_alpha(d ^ s, d);
            OP_SRCAND:      res.pixel_out = keep_alpha(d & s, d);
            OP_SRCPAINT:    res.pixel_out = keep_alpha(d | s, d);
            OP_MERGECOPY:   res.pixel_out = keep_alpha(s & p, d);
            OP_MERGEPAINT:  res.pixel_out = keep_alpha(~s | d, d);
            OP_PATCOPY:     res.pixel_out = cfg.brush_solid ? brush_argb : keep_alpha(p, d);
            // solid brush xors the whole word, alpha included
            OP_PATINVERT:   res.pixel_out = cfg.brush_solid ? (d ^ brush_argb)
                                                            : keep_alpha(p ^ d, d);
            OP_PATPAINT:    res.pixel_out = keep_alpha(d | p | ~s, d);
            OP_R2_BLACK:     res.pixel_out = '0;
            OP_R2_NOTMERGE:  res.pixel_out = ~(d | pen);
            OP_R2_MASKNOT:   res.pixel_out = d & ~pen;
            OP_R2_NOTCOPY:   res.pixel_out = ~pen;
            OP_R2_MASKPNOT:  res.pixel_out = pen & ~d;
            OP_R2_NOT:       res.pixel_out = ~d;
            OP_R2_XOR:       res.pixel_out = d ^ pen;
            OP_R2_NOTMASK:   res.pixel_out = ~(d & pen);
            OP_R2_MASK:      res.pixel_out = d & pen;
            OP_R2_NOTXOR:    res.pixel_out = ~(d ^ pen);
            OP_R2_NOP:       res.pixel_out = d;
            OP_R2_MERGENOT:  res.pixel_out = d | ~pen;
            OP_R2_COPY:      res.pixel_out = pen;
            OP_R2_MERGEPNOT: res.pixel_out = pen | ~d;
            OP_R2_MERGE:     res.pixel_out = pen | d;
            // white pen leaves the alpha byte clear
            OP_R2_WHITE:     res.pixel_out = COLOR_MASK;
            default:
            begin
                res.pixel_out = d;
                res.error     = 1'b1;
            end
        endcase
    end

endmodule

// File: sv/raster_op_pixel_unit.sv
// Raster-op pixel unit: takes one item per clock cycle while results are taken, and
// returns one result per item. An accepted item is held in an input register, combined
// by the raster-op logic and written to the result register once that register is free;
// the result register drives the master side. The input and result registers form a
// two-stage pipeline that sustains one item every cycle while the master side is ready
// and absorbs stalls on the master side. The raster-op logic reads the configuration
// when an item leaves the input register, so the user must write configuration only
// while no item is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module raster_op_pixel_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [ropu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ropu_pkg::CFG_DAT_W-1:0]  cfg_data,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // opcode[5:0], src_pixel[37:6], dst_pixel[69:38], pattern_pixel[101:70],
    // glyph_mask[109:102], zero[111:110]
    input  logic [ropu_pkg::S_TDATA_W-1:0]  s_tdata,
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_out[31:0]
    output logic [ropu_pkg::M_TDATA_W-1:0]  m_tdata,
    // error[0]
    output logic                            m_tuser
);
    import ropu_pkg::*;

    ropu_cfg_t cfg;
    ropu_res_t res;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [OPCODE_W-1:0]  opcode_reg;
    logic [PIXEL_W-1:0]   src_reg;
    logic [PIXEL_W-1:0]   dst_reg;
    logic [PIXEL_W-1:0]   pat_reg;
    logic [GLYPH_W-1:0]   glyph_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [PIXEL_W-1:0]   pixel_reg;
    logic                 error_reg;

    logic                 out_free;
    logic                 advance;
    logic                 take_in;

    ropu_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ropu_alu u_alu (
        .cfg           (cfg),
        .opcode        (opcode_reg),
        .src_pixel     (src_reg),
        .dst_pixel     (dst_reg),
        .pattern_pixel (pat_reg),
        .glyph_mask    (glyph_reg),
        .res           (res)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign take_in  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take_in)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            opcode_reg <= s_tdata[5:0];
            src_reg    <= s_tdata[37:6];
            dst_reg    <= s_tdata[69:38];
            pat_reg    <= s_tdata[101:70];
            glyph_reg  <= s_tdata[109:102];
        end
        if (advance)
        begin
            pixel_reg <= res.pixel_out;
            error_reg <= res.error;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pixel_reg;
    assign m_tuser  = error_reg;

    // a stalled input stage keeps its item
    `ROPU_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !out_free, in_valid_reg)
    // an item leaving the input stage shows up as a result next cycle
    `ROPU_ASSERT_NEXT(a_adv_result, clk, rst_n, advance, m_tvalid)
    // the slave side only backs up when both stages are full
    `ROPU_ASSERT_IMPL(a_ready_full, clk, rst_n, !s_tready, in_valid_reg && m_tvalid)

endmodule
